@@ hw/rtl/lsbsg_pkg.sv @@
// shared types, register indexes and reset values for the stego grid codec
package lsbsg_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_STEP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CHARS    = 3'd4;

  localparam logic        MODE_EXTRACT = 1'b0;
  localparam logic        MODE_EMBED   = 1'b1;

  localparam logic [11:0] WIDTH_RST     = 12'd640;
  localparam logic [11:0] HEIGHT_RST    = 12'd480;
  localparam logic [7:0]  STEP_RST      = 8'd30;
  localparam logic [11:0] MAX_CHARS_RST = 12'd255;

  localparam logic [12:0] COUNT_MAX = 13'd8191;

  // which third of a character the next carrier pixel holds
  localparam logic [1:0] PHASE_HIGH = 2'd0;
  localparam logic [1:0] PHASE_MID  = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] message_char;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       char_valid;
    logic [7:0] char_out;
    logic       next_char;
    logic       finished;
  } result_t;

endpackage

@@ hw/rtl/lsb_stego_grid_codec.sv @@
// top level of the lsb stego grid codec: grid tracking, embed/extract, output buffering
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  pixel    | in        | pixel_valid / pixel_ready   | lsbsg_pkg::pixel_t
//  result   | out       | result_valid / result_ready | lsbsg_pkg::result_t
//  config   | in        | cfg_write (no wait)         | cfg_index, cfg_data
//
// one item per cycle sustained while out does not stall; results are registered
// all per-pixel work sits between the input port and the result register
// a skid register behind the result register lets one more item in while out is stalled
// pixel_ready drops only while the skid register is full
// synchronous reset clears position, message progress and config to defaults
module lsb_stego_grid_codec #(
  parameter int COORD_BITS = lsbsg_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  lsbsg_pkg::pixel_t                    pixel,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output lsbsg_pkg::result_t                   result,
  input  logic                                 cfg_write,
  input  logic [lsbsg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lsbsg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // compare width: wide enough for coordinate plus step without wrap
  localparam int CMP_BITS = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;

  // configuration registers
  logic        mode;
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [7:0]  grid_step;
  logic [11:0] max_chars;

  // progress state
  logic [COORD_BITS-1:0] col_pos, col_pos_next;
  logic [COORD_BITS-1:0] row_pos, row_pos_next;
  logic [7:0]            col_phase, col_phase_next;
  logic [7:0]            row_phase, row_phase_next;
  logic [1:0]            bit_phase, bit_phase_next;
  logic [7:0]            char_accum, char_accum_next;
  logic [12:0]           char_count, char_count_next;
  logic                  done_flag, done_flag_next;

  // output buffering
  lsbsg_pkg::result_t result_new;
  lsbsg_pkg::result_t skid;
  logic               skid_valid;
  logic               pixel_fire;

  // working copies of state after an optional frame_start clear
  logic [COORD_BITS-1:0] col_cur, row_cur;
  logic [7:0]            col_ph_cur, row_ph_cur;
  logic [1:0]            bit_ph_cur;
  logic [7:0]            accum_cur;
  logic [12:0]           count_cur, count_inc;
  logic                  done_cur;
  logic [7:0]            step;
  logic [CMP_BITS-1:0]   col_ext, row_ext, width_ext, height_ext, step_ext;
  logic                  on_grid, active;
  logic [7:0]            ch, r, g, b, cout;
  logic [8:0]            col_ph_inc, row_ph_inc;

  assign pixel_ready = !skid_valid;
  assign pixel_fire  = pixel_valid && pixel_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lsbsg_pkg::MODE_EXTRACT;
      image_width  <= lsbsg_pkg::WIDTH_RST;
      image_height <= lsbsg_pkg::HEIGHT_RST;
      grid_step    <= lsbsg_pkg::STEP_RST;
      max_chars    <= lsbsg_pkg::MAX_CHARS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lsbsg_pkg::REG_MODE:         mode         <= cfg_data[0];
        lsbsg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        lsbsg_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[11:0];
        lsbsg_pkg::REG_GRID_STEP:    grid_step    <= cfg_data[7:0];
        lsbsg_pkg::REG_MAX_CHARS:    max_chars    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // per-pixel datapath
  always_comb begin
    // frame_start clears all progress state before the pixel is looked at
    if (pixel.frame_start) begin
      col_cur    = '0;
      row_cur    = '0;
      col_ph_cur = '0;
      row_ph_cur = '0;
      bit_ph_cur = lsbsg_pkg::PHASE_HIGH;
      accum_cur  = '0;
      count_cur  = '0;
      done_cur   = 1'b0;
    end else begin
      col_cur    = col_pos;
      row_cur    = row_pos;
      col_ph_cur = col_phase;
      row_ph_cur = row_phase;
      bit_ph_cur = bit_phase;
      accum_cur  = char_accum;
      count_cur  = char_count;
      done_cur   = done_flag;
    end

    // a zero step behaves as one
    step       = (grid_step == 8'd0) ? 8'd1 : grid_step;
    col_ext    = CMP_BITS'(col_cur);
    row_ext    = CMP_BITS'(row_cur);
    width_ext  = CMP_BITS'(image_width);
    height_ext = CMP_BITS'(image_height);
    step_ext   = CMP_BITS'(step);

    on_grid = (col_cur != '0) && (col_ph_cur == 8'd0) && (col_ext + step_ext <= width_ext) &&
              (row_cur != '0) && (row_ph_cur == 8'd0) && (row_ext + step_ext <= height_ext);
    active  = on_grid && !done_cur;

    ch    = pixel.message_char;
    r     = pixel.red_in;
    g     = pixel.green_in;
    b     = pixel.blue_in;
    cout  = '0;
    count_inc = (count_cur < lsbsg_pkg::COUNT_MAX) ? count_cur + 13'd1 : count_cur;

    bit_phase_next  = bit_ph_cur;
    char_accum_next = accum_cur;
    char_count_next = count_cur;
    done_flag_next  = done_cur;
    result_new.char_valid = 1'b0;
    result_new.next_char  = 1'b0;

    if (active) begin
      if (mode == lsbsg_pkg::MODE_EMBED) begin
        case (bit_ph_cur)
          lsbsg_pkg::PHASE_HIGH: begin
            r = {r[7:1], ch[7]};
            g = {g[7:1], ch[6]};
            b = {b[7:1], ch[5]};
            bit_phase_next = lsbsg_pkg::PHASE_MID;
          end
          lsbsg_pkg::PHASE_MID: begin
            r = {r[7:1], ch[4]};
            g = {g[7:1], ch[3]};
            b = {b[7:1], ch[2]};
            bit_phase_next = lsbsg_pkg::PHASE_LOW;
          end
          default: begin
            r = {r[7:1], ch[1]};
            g = {g[7:1], ch[0]};
            bit_phase_next = lsbsg_pkg::PHASE_HIGH;
            result_new.next_char = 1'b1;
            char_count_next = count_inc;
            if (ch == 8'd0) begin
              done_flag_next = 1'b1;
            end
          end
        endcase
      end else begin
        case (bit_ph_cur)
          lsbsg_pkg::PHASE_HIGH: begin
            char_accum_next = {r[0], g[0], b[0], 5'd0};
            bit_phase_next  = lsbsg_pkg::PHASE_MID;
          end
          lsbsg_pkg::PHASE_MID: begin
            char_accum_next = accum_cur | {3'd0, r[0], g[0], b[0], 2'd0};
            bit_phase_next  = lsbsg_pkg::PHASE_LOW;
          end
          default: begin
            cout = accum_cur | {6'd0, r[0], g[0]};
            result_new.char_valid = 1'b1;
            char_accum_next = '0;
            bit_phase_next  = lsbsg_pkg::PHASE_HIGH;
            char_count_next = count_inc;
            // length limit counts the character just finished
            if ((cout == 8'd0) || (count_inc > {1'b0, max_chars})) begin
              done_flag_next = 1'b1;
            end
          end
        endcase
      end
    end

    // raster position, wraps at the configured image size
    col_ph_inc = {1'b0, col_ph_cur} + 9'd1;
    row_ph_inc = {1'b0, row_ph_cur} + 9'd1;
    if (col_ext + CMP_BITS'(1) >= width_ext) begin
      col_pos_next   = '0;
      col_phase_next = '0;
      if (row_ext + CMP_BITS'(1) >= height_ext) begin
        row_pos_next   = '0;
        row_phase_next = '0;
      end else begin
        row_pos_next   = row_cur + COORD_BITS'(1);
        row_phase_next = (row_ph_inc >= {1'b0, step}) ? 8'd0 : row_ph_inc[7:0];
      end
    end else begin
      col_pos_next   = col_cur + COORD_BITS'(1);
      col_phase_next = (col_ph_inc >= {1'b0, step}) ? 8'd0 : col_ph_inc[7:0];
      row_pos_next   = row_cur;
      row_phase_next = row_ph_cur;
    end

    result_new.red_out   = r;
    result_new.green_out = g;
    result_new.blue_out  = b;
    result_new.char_out  = cout;
    result_new.finished  = done_flag_next;
  end

  // progress state advances on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      col_phase  <= '0;
      row_phase  <= '0;
      bit_phase  <= lsbsg_pkg::PHASE_HIGH;
      char_accum <= '0;
      char_count <= '0;
      done_flag  <= 1'b0;
    end else if (pixel_fire) begin
      col_pos    <= col_pos_next;
      row_pos    <= row_pos_next;
      col_phase  <= col_phase_next;
      row_phase  <= row_phase_next;
      bit_phase  <= bit_phase_next;
      char_accum <= char_accum_next;
      char_count <= char_count_next;
      done_flag  <= done_flag_next;
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= pixel_fire;
      end
    end else if (pixel_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result <= skid;
      end else if (pixel_fire) begin
        result <= result_new;
      end
    end else if (pixel_fire) begin
      skid <= result_new;
    end
  end

  // skid stage only fills behind a waiting result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item while result register is empty");

  // a result never both completes a character and asks for the next
  a_char_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.char_valid && result.next_char))
    else $error("char_valid and next_char both set");

  // finishing sticks until a new frame
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (pixel_fire && done_flag && !pixel.frame_start) |=> done_flag)
    else $error("done flag dropped without frame_start");

  // the character phase never reaches the unused code
  a_bit_phase_range: assert property (@(posedge clk) disable iff (rst)
    bit_phase != 2'd3)
    else $error("bit phase out of range");

endmodule
